FILE: design/slis_pkg.sv
package slis_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int RSP_CNT_WIDTH  = 5;
   localparam int CAPACITY_DEF   = 16;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } slis_state_type;

   // what each cell hands to the cell above it
   typedef struct packed {
      logic                         valid;
      logic                         less;
      logic signed [DATA_WIDTH-1:0] value;
   } slis_link_type;

   typedef struct packed {
      logic exec;
      logic reply;
   } slis_ctrl_type;

   typedef struct packed {
      logic ins_en;
      logic cmp_en;
   } slis_cell_ctl_type;

endpackage

FILE: design/slis_cell.sv
module slis_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  slis_pkg::slis_cell_ctl_type           ctl,
   input  logic signed [slis_pkg::DATA_WIDTH-1:0] key,
   input  slis_pkg::slis_link_type               link_lo,
   output slis_pkg::slis_link_type               link_hi,
   output logic                                  match
);
   import slis_pkg::*;

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;
   logic                         match_ff, match_in;
   logic                         less;

   assign less = valid_ff && (value_ff < key);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctl.ins_en) begin
         valid_in = link_lo.valid;
         if (!less) begin
            // either the new key lands here or the entry below moves up
            value_in = link_lo.less ? key : link_lo.value;
         end
      end
      if (ctl.cmp_en) begin
         match_in = valid_ff && (value_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      value_ff <= value_in;
   end

   assign link_hi.valid = valid_ff;
   assign link_hi.less  = less;
   assign link_hi.value = value_ff;
   assign match         = match_ff;

endmodule

FILE: design/slis_ctrl.sv
module slis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output slis_pkg::slis_ctrl_type ctrl
);
   import slis_pkg::*;

   slis_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC:  state_in = ST_REPLY;
         ST_REPLY: state_in = start ? ST_EXEC : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      ctrl.exec  = 1'b0;
      ctrl.reply = 1'b0;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            busy      = 1'b1;
            ctrl.exec = 1'b1;
         end
         ST_REPLY: begin
            ctrl.reply = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/sorted_list_insert_search.sv
// Sorted list of signed 32-bit values held in a row of CAPACITY cells, one entry per
// cell, ascending from cell 0. An item is taken when start is high and busy is low.
// Each item has an execute state, then a reply state. In the execute state, every cell
// compares the key with its own entry at once and an insert shifts the larger entries
// up one cell; in the reply state, the result is on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe, and the next item may already be taken in that cycle.
// The receiver cannot stall: a result not taken in its cycle is gone. An insert into a
// full list is rejected with rsp_status high; every result carries the entry count.
module sorted_list_insert_search #(
   parameter int CAPACITY = slis_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic signed [slis_pkg::DATA_WIDTH-1:0] req_item_value,
   output logic                                  rsp_strobe,
   output logic                                  rsp_found,
   output logic                                  rsp_status,
   output logic [slis_pkg::RSP_CNT_WIDTH-1:0]    rsp_entry_count
);
   import slis_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   slis_ctrl_type                ctrl;
   slis_cell_ctl_type            cell_ctl;
   slis_link_type                link [CAPACITY+1];
   logic [CAPACITY-1:0]          match;

   logic                         action_ff;
   logic signed [DATA_WIDTH-1:0] key_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         status_ff, status_in;
   logic                         accept;
   logic                         full;

   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(CAPACITY));

   slis_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   assign cell_ctl.ins_en = ctrl.exec && (action_ff == ACT_INSERT) && !full;
   assign cell_ctl.cmp_en = ctrl.exec;

   // below cell 0 sits an always-valid, always-smaller neighbour
   assign link[0].valid = 1'b1;
   assign link[0].less  = 1'b1;
   assign link[0].value = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slis_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .key     (key_ff),
         .link_lo (link[i]),
         .link_hi (link[i+1]),
         .match   (match[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (ctrl.exec) begin
         status_in = STATUS_DONE;
         if (action_ff == ACT_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= STATUS_DONE;
      end else begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= req_item_value;
      end
   end

   assign rsp_strobe      = ctrl.reply;
   assign rsp_found       = (action_ff == ACT_SEARCH) && (|match);
   assign rsp_status      = status_ff;
   assign rsp_entry_count = RSP_CNT_WIDTH'(count_ff);

   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_found && rsp_status))
      else $error("found and overflow reported together");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item not executed");

   a_exec_reply: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("executed item gave no result");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> full)
      else $error("insert rejected while list not full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

endmodule
